// File: hw/rtl/assert_macros.svh
// Assertion macros used by the parity filter deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define PFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define PFD_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/pfd_pkg.sv
// Shared types and constants of the parity filter deque.
package pfd_pkg;

	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK     = 3'd0,
		OP_PUSH_FRONT    = 3'd1,
		OP_DROP_EVEN     = 3'd2,
		OP_DROP_ODD      = 3'd3,
		OP_KEEP_ODD_POS  = 3'd4,
		OP_KEEP_EVEN_POS = 3'd5,
		OP_DUMP          = 3'd6
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_FILT,
		S_DRD,
		S_DWT,
		S_RESP
	} state_t;

endpackage

// File: hw/rtl/pfd_ifs.sv
// Command and result channel interfaces of the parity filter deque.
interface pfd_cmd_if import pfd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           opcode;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);
endinterface

interface pfd_res_if import pfd_pkg::*; #(parameter int ENTRIES_W = 7) ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] item;
	logic                      last_of_run;
	logic [STATUS_W-1:0]       status;
	logic [ENTRIES_W-1:0]      entries;

	modport source (output valid, output item, output last_of_run, output status,
		output entries, input ready);
	modport sink (input valid, input item, input last_of_run, input status,
		input entries, output ready);
endinterface

// File: hw/rtl/pfd_store.sv
// Element store: one write port, one read port with registered read data.
module pfd_store import pfd_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [VALUE_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [VALUE_W-1:0] rdata
);

	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/parity_filter_deque.sv
// Parity filter deque: bounded circular deque of signed words with filter and dump.
// Each command word is taken in the idle state and worked through by a small
// sequencer around one single-port-write, single-port-read element memory; the
// block takes no new command until the last result word of the current one has
// been loaded into the output register (that register may still be waiting for
// the sink when the next command is taken). A push, an unused opcode or any
// command on an empty store goes straight from the execute state to the
// response state. A filter streams the stored elements through the memory read
// port and writes survivors back through the write port. A dump reads each
// element and loads it into the output register once the sink has room.
// The store needs no clearing pass: only written entries are ever read.
`include "assert_macros.svh"

module parity_filter_deque import pfd_pkg::*; #(
	parameter int DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	pfd_cmd_if.sink    cmd,
	pfd_res_if.source  res
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	// head + offset wrapped into the store; head below DEPTH, offset at most DEPTH
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(h) + SW'(off);
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	state_t             state_q, state_d;
	logic [OP_W-1:0]    op_q;
	logic [VALUE_W-1:0] val_q;
	logic [AW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rd_q;
	logic [CW-1:0]      wr_q;
	logic               pend_s1;
	logic               pos_odd_s1;
	status_t            res_status_q;

	logic               out_valid_q;
	logic [VALUE_W-1:0] out_item_q;
	logic               out_last_q;
	status_t            out_status_q;
	logic [CW-1:0]      out_entries_q;

	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [VALUE_W-1:0] mem_wdata, mem_rdata;

	logic               is_push, is_front, is_full, is_empty, op_unused;
	logic               filt_more, filt_done, rd_last, out_free, out_load, keep;
	logic [AW-1:0]      head_dec;
	logic [CW-1:0]      wr_off;

	assign is_push   = (op_q == OP_PUSH_BACK) || (op_q == OP_PUSH_FRONT);
	assign is_front  = (op_q == OP_PUSH_FRONT);
	assign is_full   = (count_q == CW'(DEPTH));
	assign is_empty  = (count_q == '0);
	assign op_unused = (op_q > OP_DUMP);
	assign filt_more = (rd_q != count_q);
	assign filt_done = !filt_more && !pend_s1;
	assign rd_last   = (CW'(rd_q + CW'(1)) == count_q);
	assign out_free  = !out_valid_q || res.ready;
	assign head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : AW'(head_q - AW'(1));
	assign wr_off    = (state_q == S_EXEC) ? count_q : wr_q;

	always_comb begin
		case (op_q)
			OP_DROP_EVEN:    keep = mem_rdata[0];
			OP_DROP_ODD:     keep = !mem_rdata[0];
			OP_KEEP_ODD_POS: keep = pos_odd_s1;
			default:         keep = !pos_odd_s1;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (is_push || op_unused || is_empty) begin
					state_d = S_RESP;
				end else if (op_q == OP_DUMP) begin
					state_d = S_DRD;
				end else begin
					state_d = S_FILT;
				end
			end
			S_FILT: begin
				if (filt_done) begin
					state_d = S_RESP;
				end
			end
			S_DRD: begin
				state_d = S_DWT;
			end
			S_DWT: begin
				if (out_free) begin
					state_d = rd_last ? S_IDLE : S_DRD;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd.ready = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = mem_rdata;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
			end
			S_EXEC: begin
				mem_we    = is_push && !is_full;
				mem_wdata = val_q;
			end
			S_FILT: begin
				mem_re = filt_more;
				mem_we = pend_s1 && keep;
			end
			S_DRD: begin
				mem_re = 1'b1;
			end
			S_DWT: begin
				out_load = out_free;
			end
			S_RESP: begin
				out_load = out_free;
			end
			default: begin
				cmd.ready = 1'b0;
			end
		endcase
	end

	assign mem_raddr = slot(head_q, rd_q);
	assign mem_waddr = (state_q == S_EXEC && is_front) ? head_dec : slot(head_q, wr_off);

	pfd_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// command word capture and filter position parity
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd.valid) begin
			op_q  <= cmd.opcode;
			val_q <= cmd.value;
		end
		pos_odd_s1 <= !rd_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			rd_q         <= '0;
			wr_q         <= '0;
			pend_s1      <= 1'b0;
			res_status_q <= ST_OK;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == S_FILT) && mem_re;
			case (state_q)
				S_EXEC: begin
					rd_q <= '0;
					wr_q <= '0;
					if (is_push) begin
						if (is_full) begin
							res_status_q <= ST_FULL;
						end else begin
							res_status_q <= ST_OK;
							count_q      <= CW'(count_q + CW'(1));
							if (is_front) begin
								head_q <= head_dec;
							end
						end
					end else if (!op_unused && is_empty) begin
						res_status_q <= ST_EMPTY;
					end else begin
						res_status_q <= ST_OK;
					end
				end
				S_FILT: begin
					if (mem_re) begin
						rd_q <= CW'(rd_q + CW'(1));
					end
					if (mem_we) begin
						wr_q <= CW'(wr_q + CW'(1));
					end
					// commit the compacted length
					if (filt_done) begin
						count_q <= wr_q;
					end
				end
				S_DWT: begin
					if (out_free) begin
						rd_q <= CW'(rd_q + CW'(1));
					end
				end
				default: begin
					rd_q <= rd_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_item_q    <= (state_q == S_DWT) ? mem_rdata : '0;
			out_last_q    <= (state_q == S_DWT) ? rd_last : 1'b1;
			out_status_q  <= (state_q == S_DWT) ? ST_OK : res_status_q;
			out_entries_q <= count_q;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.item        = out_item_q;
	assign res.last_of_run = out_last_q;
	assign res.status      = out_status_q;
	assign res.entries     = out_entries_q;

	`PFD_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "entry count above store depth")
	`PFD_ASSERT(a_wr_behind_rd, (state_q == S_FILT) |-> (wr_q <= rd_q), "filter write ahead of read")
	`PFD_ASSERT_NEVER(a_rw_clash, mem_we && mem_re && (mem_waddr == mem_raddr), "read and write same slot")
	`PFD_ASSERT(a_dump_end, (out_load && state_q == S_DWT && rd_last) |=> (state_q == S_IDLE && out_valid_q && out_last_q), "dump end not marked")

endmodule
